// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/frp_pkg.sv =====
// types, constants and control structs of the frame pacing timer
`default_nettype none

package frp_pkg;

   localparam int CFG_W       = 32;
   localparam int MULT_W      = 4;
   localparam int COUNT_W     = 64;
   localparam int DELTA_W     = 35;
   localparam int HIST_LOG2   = 2;
   localparam int HIST_DEPTH  = 1 << HIST_LOG2;
   localparam int SUM_W       = DELTA_W + HIST_LOG2;
   localparam int SLOW_FACTOR = 8;
   localparam int LIM_W       = CFG_W + $clog2(SLOW_FACTOR);
   localparam int ACC_W       = DELTA_W + 1;
   localparam int GROUP_W     = CFG_W + MULT_W;
   localparam int THR_W       = GROUP_W + 1;
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + (1 << MULT_W));
   localparam int CSR_IDX_W   = 2;

   localparam logic [CFG_W-1:0]  RESET_PERIOD = CFG_W'(166667);
   localparam logic [CFG_W-1:0]  RESET_TOL    = CFG_W'(2000);
   localparam logic [MULT_W-1:0] RESET_MULT   = MULT_W'(1);
   localparam logic [SUM_W-1:0]  RESET_SUM    = SUM_W'(HIST_DEPTH) * SUM_W'(RESET_PERIOD);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_PERIOD = 2'd0,
      CSR_VSYNC_BASE   = 2'd1,
      CSR_SNAP_TOL     = 2'd2,
      CSR_UPDATE_MULT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      SNAP_ONE,
      SNAP_TWO,
      SNAP_THREE,
      SNAP_FOUR,
      SNAP_HALF
   } snap_sel_type;

   typedef struct packed {
      logic         load;
      logic         clamp;
      logic         snap;
      snap_sel_type snap_sel;
      logic         hist;
      logic         add;
      logic         resync;
      logic         emit_pulse;
      logic         emit_idle;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic              snap_hit;
      logic              group_ok;
      logic              more_ok;
      logic [MULT_W-1:0] mult;
      logic              out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/frp_dpath.sv =====
// datapath: config registers, delta, snap, history average, accumulator, result register
`default_nettype none

module frp_dpath
   import frp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   input  wire logic [COUNT_W-1:0]   req_counter_value,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_update_now,
   output logic [DELTA_W-1:0]        rsp_smoothed_delta,
   output logic [DELTA_W-1:0]        rsp_accumulator_left,
   output logic                      rsp_resynced,
   output logic                      rsp_last
);

   logic [CFG_W-1:0]   period_ff, period_in;
   logic [CFG_W-1:0]   base_ff, base_in;
   logic [CFG_W-1:0]   tol_ff, tol_in;
   logic [MULT_W-1:0]  mult_ff, mult_in;
   logic [COUNT_W-1:0] prev_ff, prev_in;
   logic [COUNT_W-1:0] diff_ff, diff_in;
   logic [LIM_W-1:0]   limit_ff, limit_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [DELTA_W-1:0] three_ff, three_in;
   logic [CFG_W-1:0]   half_ff, half_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [DELTA_W-1:0] hist_ff [HIST_DEPTH];
   logic [DELTA_W-1:0] hist_in [HIST_DEPTH];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DELTA_W-1:0] smooth_ff, smooth_in;
   logic               rs_ff, rs_in;
   logic               pending_ff, pending_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_pulse_ff, out_pulse_in;
   logic [DELTA_W-1:0] out_smooth_ff, out_smooth_in;
   logic [DELTA_W-1:0] out_acc_ff, out_acc_in;
   logic               out_rs_ff, out_rs_in;
   logic               out_last_ff, out_last_in;

   logic [MULT_W-1:0]  mult_eff;
   logic [DELTA_W-1:0] target;
   logic [DELTA_W-1:0] abs_diff;
   logic               snap_hit;
   logic               diff_big;
   logic [DELTA_W-1:0] clamped;
   logic [DELTA_W-1:0] smooth_avg;
   logic [ACC_W-1:0]   acc_sub;
   logic [CFG_W:0]     base_inc;
   logic               out_free;

   assign mult_eff = (mult_ff == '0) ? MULT_W'(1) : mult_ff;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.snap_sel)
         SNAP_ONE:   target = DELTA_W'(base_ff);
         SNAP_TWO:   target = DELTA_W'({base_ff, 1'b0});
         SNAP_THREE: target = three_ff;
         SNAP_FOUR:  target = DELTA_W'({base_ff, 2'b00});
         SNAP_HALF:  target = DELTA_W'(half_ff);
         default:    target = DELTA_W'(base_ff);
      endcase
   end

   assign abs_diff = (delta_ff >= target) ? (delta_ff - target) : (target - delta_ff);
   assign snap_hit = abs_diff < DELTA_W'(tol_ff);

   // differences beyond the slow-frame limit count as one period, negative differences as zero
   assign diff_big = (diff_ff[COUNT_W-1:LIM_W] != '0) || (diff_ff[LIM_W-1:0] > limit_ff);
   assign clamped  = diff_ff[COUNT_W-1] ? '0 :
                     diff_big ? DELTA_W'(period_ff) : diff_ff[DELTA_W-1:0];

   assign smooth_avg = sum_ff[SUM_W-1:HIST_LOG2];
   assign acc_sub    = acc_ff - ACC_W'(period_ff);
   assign base_inc   = {1'b0, base_ff} + (CFG_W+1)'(1);

   assign status.snap_hit = snap_hit;
   assign status.group_ok = (period_ff != '0) && (THR_W'(acc_ff) >= THR_W'(group_ff));
   assign status.more_ok  = THR_W'(acc_ff) >= thr_ff;
   assign status.mult     = mult_eff;
   assign status.out_free = out_free;

   always_comb begin
      period_in     = period_ff;
      base_in       = base_ff;
      tol_in        = tol_ff;
      mult_in       = mult_ff;
      prev_in       = prev_ff;
      diff_in       = diff_ff;
      limit_in      = limit_ff;
      group_in      = group_ff;
      thr_in        = thr_ff;
      three_in      = three_ff;
      half_in       = half_ff;
      delta_in      = delta_ff;
      hist_in       = hist_ff;
      sum_in        = sum_ff;
      acc_in        = acc_ff;
      smooth_in     = smooth_ff;
      rs_in         = rs_ff;
      pending_in    = pending_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_pulse_in  = out_pulse_ff;
      out_smooth_in = out_smooth_ff;
      out_acc_in    = out_acc_ff;
      out_rs_in     = out_rs_ff;
      out_last_in   = out_last_ff;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_PERIOD: period_in = csr_data;
            CSR_VSYNC_BASE:   base_in   = csr_data;
            CSR_SNAP_TOL:     tol_in    = csr_data;
            CSR_UPDATE_MULT:  mult_in   = csr_data[MULT_W-1:0];
            default:          period_in = period_ff;
         endcase
      end

      if (cmd.load) begin
         diff_in  = req_counter_value - prev_ff;
         prev_in  = req_counter_value;
         limit_in = LIM_W'(period_ff) * LIM_W'(SLOW_FACTOR);
         group_in = GROUP_W'(period_ff) * GROUP_W'(mult_eff);
         three_in = DELTA_W'({base_ff, 1'b0}) + DELTA_W'(base_ff);
         half_in  = base_inc[CFG_W:1];
      end

      if (cmd.clamp) begin
         delta_in = clamped;
         // next group needs one more period on top of the group size
         thr_in   = THR_W'(group_ff) + THR_W'(period_ff);
      end

      if (cmd.snap && snap_hit) begin
         delta_in = target;
      end

      if (cmd.hist) begin
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HIST_DEPTH-1] = delta_ff;
         sum_in = sum_ff - SUM_W'(hist_ff[0]) + SUM_W'(delta_ff);
      end

      if (cmd.add) begin
         acc_in    = acc_ff + ACC_W'(smooth_avg);
         smooth_in = smooth_avg;
      end

      if (cmd.resync) begin
         if (pending_ff || (acc_ff > ACC_W'(limit_ff))) begin
            acc_in    = '0;
            smooth_in = DELTA_W'(period_ff);
            rs_in     = 1'b1;
         end else begin
            rs_in = 1'b0;
         end
         pending_in = 1'b0;
      end

      if (cmd.emit_pulse) begin
         acc_in        = acc_sub;
         out_valid_in  = 1'b1;
         out_pulse_in  = 1'b1;
         out_smooth_in = smooth_ff;
         out_acc_in    = acc_sub[DELTA_W-1:0];
         out_rs_in     = rs_ff;
         out_last_in   = cmd.last;
      end else if (cmd.emit_idle) begin
         out_valid_in  = 1'b1;
         out_pulse_in  = 1'b0;
         out_smooth_in = smooth_ff;
         out_acc_in    = acc_ff[DELTA_W-1:0];
         out_rs_in     = rs_ff;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= RESET_PERIOD;
         base_ff      <= RESET_PERIOD;
         tol_ff       <= RESET_TOL;
         mult_ff      <= RESET_MULT;
         prev_ff      <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= DELTA_W'(RESET_PERIOD);
         end
         sum_ff       <= RESET_SUM;
         acc_ff       <= '0;
         pending_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         base_ff      <= base_in;
         tol_ff       <= tol_in;
         mult_ff      <= mult_in;
         prev_ff      <= prev_in;
         hist_ff      <= hist_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      limit_ff      <= limit_in;
      group_ff      <= group_in;
      thr_ff        <= thr_in;
      three_ff      <= three_in;
      half_ff       <= half_in;
      delta_ff      <= delta_in;
      smooth_ff     <= smooth_in;
      rs_ff         <= rs_in;
      out_pulse_ff  <= out_pulse_in;
      out_smooth_ff <= out_smooth_in;
      out_acc_ff    <= out_acc_in;
      out_rs_ff     <= out_rs_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_update_now       = out_pulse_ff;
   assign rsp_smoothed_delta   = out_smooth_ff;
   assign rsp_accumulator_left = out_acc_ff;
   assign rsp_resynced         = out_rs_ff;
   assign rsp_last             = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frp_ctrl.sv =====
// controller: sequences the datapath steps and the update pulses of one frame
`default_nettype none

module frp_ctrl
   import frp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_SNAP,
      ST_HIST,
      ST_ADD,
      ST_RESYNC,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   snap_sel_type      snap_ff, snap_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MULT_W-1:0] grp_ff, grp_in;

   logic first_room;
   logic group_room;
   logic group_end;
   logic go_on;

   assign first_room = CNT_W'(status.mult) <= CNT_W'(MAX_RESULTS);
   assign group_room = (cnt_ff + CNT_W'(1) + CNT_W'(status.mult)) <= CNT_W'(MAX_RESULTS);
   assign group_end  = grp_ff == (status.mult - MULT_W'(1));
   assign go_on      = status.more_ok && group_room;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      cmd          = '0;
      cmd.snap_sel = snap_ff;
      state_in     = state_ff;
      snap_in      = snap_ff;
      cnt_in       = cnt_ff;
      grp_in       = grp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            snap_in   = SNAP_ONE;
            state_in  = ST_SNAP;
         end
         ST_SNAP: begin
            cmd.snap = 1'b1;
            if (status.snap_hit || (snap_ff == SNAP_HALF)) begin
               state_in = ST_HIST;
            end else begin
               case (snap_ff)
                  SNAP_ONE:   snap_in = SNAP_TWO;
                  SNAP_TWO:   snap_in = SNAP_THREE;
                  SNAP_THREE: snap_in = SNAP_FOUR;
                  SNAP_FOUR:  snap_in = SNAP_HALF;
                  default:    snap_in = SNAP_HALF;
               endcase
            end
         end
         ST_HIST: begin
            cmd.hist = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_RESYNC;
         end
         ST_RESYNC: begin
            cmd.resync = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.group_ok && first_room) begin
               cnt_in   = '0;
               grp_in   = '0;
               state_in = ST_EMIT;
            end else if (status.out_free) begin
               // frame with no update still gives one transaction
               cmd.emit_idle = 1'b1;
               cmd.last      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_pulse = 1'b1;
               cmd.last       = group_end && !go_on;
               if (group_end && !go_on) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  grp_in = group_end ? '0 : grp_ff + MULT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         snap_ff  <= SNAP_ONE;
         cnt_ff   <= '0;
         grp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         snap_ff  <= snap_in;
         cnt_ff   <= cnt_in;
         grp_ff   <= grp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/frame_pacing_timer.sv =====
// top level of the frame pacing timer: controller and datapath
// the difference is formed at acceptance, then the clamp step, one to five snap compares,
// history, add, resync and check: a frame without an update then shows a single idle result,
// a frame with pulses gives one pulse a cycle in the emit state while the output is free
// a new frame is accepted only after the last result of the previous one is issued
// synchronous reset loads the register defaults, a history of 166667 and arms resync
`default_nettype none

module frame_pacing_timer
   import frp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [COUNT_W-1:0]   req_counter_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_update_now,
   output logic [DELTA_W-1:0]        rsp_smoothed_delta,
   output logic [DELTA_W-1:0]        rsp_accumulator_left,
   output logic                      rsp_resynced,
   output logic                      rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   frp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   frp_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_counter_value    (req_counter_value),
      .cmd                  (cmd),
      .status               (status),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_update_now       (rsp_update_now),
      .rsp_smoothed_delta   (rsp_smoothed_delta),
      .rsp_accumulator_left (rsp_accumulator_left),
      .rsp_resynced         (rsp_resynced),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/frp_checker.sv =====
// port-level checker of the frame pacing timer and its bind
`default_nettype none
`include "assert_macros.svh"

module frp_checker
   import frp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_update_now,
   input wire logic [DELTA_W-1:0] rsp_smoothed_delta,
   input wire logic [DELTA_W-1:0] rsp_accumulator_left,
   input wire logic               rsp_resynced,
   input wire logic               rsp_last
);

   // a stalled result transaction holds its smoothed delta, accumulator value and last flag
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_smoothed_delta) && $stable(rsp_accumulator_left) && $stable(rsp_last))

   // a frame without an update is a single transaction
   `ASSERT_IMP(a_idle_last, clock, reset, rsp_valid && !rsp_update_now, rsp_last)

   // a resync frame with no pulse leaves an empty accumulator
   `ASSERT_IMP(a_resync_zero, clock, reset, rsp_valid && rsp_resynced && !rsp_update_now, rsp_accumulator_left == '0)

   // the block works on one frame at a time
   `ASSERT_NXT(a_one_frame, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind frame_pacing_timer frp_checker u_frp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_update_now       (rsp_update_now),
   .rsp_smoothed_delta   (rsp_smoothed_delta),
   .rsp_accumulator_left (rsp_accumulator_left),
   .rsp_resynced         (rsp_resynced),
   .rsp_last             (rsp_last)
);

`default_nettype wire

// ===== bench/frame_pacing_monitor.sv =====
// channel monitor for the frame pacing timer: predicts each frame's results and compares them
`timescale 1ns / 100ps

module frame_pacing_monitor
   import frp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [COUNT_W-1:0]   req_counter_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_update_now,
   input  logic [DELTA_W-1:0]   rsp_smoothed_delta,
   input  logic [DELTA_W-1:0]   rsp_accumulator_left,
   input  logic                 rsp_resynced,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   pending_results
);

   typedef struct packed {
      logic               update_now;
      logic [DELTA_W-1:0] smoothed_delta;
      logic [DELTA_W-1:0] accumulator_left;
      logic               resynced;
      logic               last;
   } pacing_result_t;

   pacing_result_t due_results[$];

   logic [CFG_W-1:0]   period_reg;
   logic [CFG_W-1:0]   base_reg;
   logic [CFG_W-1:0]   tol_reg;
   logic [MULT_W-1:0]  mult_reg;
   logic [63:0]        prev_reading;
   logic [63:0]        delta_hist [HIST_DEPTH];
   logic [63:0]        acc_reg;
   bit                 resync_armed;
   int                 bad_results = 0;

   assign fail_count = bad_results;

   task automatic pace_frame(input logic [COUNT_W-1:0] reading);
      logic [63:0]    per, base, limit, diff, delta, gap, sum, smooth, acc, grp;
      logic [63:0]    target [5];
      int unsigned    mult, n;
      int             i;
      bit             snapped, rs;
      pacing_result_t burst [MAX_RESULTS];
      per   = 64'(period_reg);
      base  = 64'(base_reg);
      limit = per * 64'(SLOW_FACTOR);
      mult  = (mult_reg == '0) ? 1 : mult_reg;
      diff  = reading - prev_reading;
      prev_reading = reading;
      // negative difference means the counter wrapped
      if (diff[63]) begin
         delta = '0;
      end else if (diff > limit) begin
         delta = per;
      end else begin
         delta = diff;
      end
      target[0] = base;
      target[1] = base * 64'd2;
      target[2] = base * 64'd3;
      target[3] = base * 64'd4;
      target[4] = (base + 64'd1) / 64'd2;
      snapped = 1'b0;
      for (i = 0; i < 5; i++) begin
         gap = (delta > target[i]) ? delta - target[i] : target[i] - delta;
         if (!snapped && gap < 64'(tol_reg)) begin
            delta   = target[i];
            snapped = 1'b1;
         end
      end
      for (i = 0; i < HIST_DEPTH - 1; i++) begin
         delta_hist[i] = delta_hist[i + 1];
      end
      delta_hist[HIST_DEPTH - 1] = delta;
      sum = '0;
      for (i = 0; i < HIST_DEPTH; i++) begin
         sum += delta_hist[i];
      end
      smooth = sum / 64'(HIST_DEPTH);
      acc = acc_reg + smooth;
      rs  = 1'b0;
      if (acc > limit) begin
         resync_armed = 1'b1;
      end
      if (resync_armed) begin
         acc          = '0;
         smooth       = per;
         resync_armed = 1'b0;
         rs           = 1'b1;
      end
      n = 0;
      if (per != '0) begin
         grp = per * 64'(mult);
         // whole groups only, and never more pulses than the frame allows
         while (acc >= grp && n + mult <= MAX_RESULTS) begin
            for (i = 0; i < mult; i++) begin
               acc -= per;
               burst[n] = {1'b1, smooth[DELTA_W-1:0], acc[DELTA_W-1:0], rs, 1'b0};
               n++;
            end
         end
      end
      acc_reg = acc;
      if (n == 0) begin
         due_results.push_back({1'b0, smooth[DELTA_W-1:0], acc[DELTA_W-1:0], rs, 1'b1});
      end else begin
         burst[n - 1].last = 1'b1;
         for (i = 0; i < n; i++) begin
            due_results.push_back(burst[i]);
         end
      end
   endtask

   task automatic check_result();
      pacing_result_t seen, want;
      seen = {rsp_update_now, rsp_smoothed_delta, rsp_accumulator_left, rsp_resynced, rsp_last};
      if (due_results.size() == 0) begin
         bad_results++;
         if (bad_results <= 10) begin
            $display("%0t: result with no frame pending: upd=%0d delta=%0d acc=%0d rs=%0d last=%0d",
                     $time, seen.update_now, seen.smoothed_delta, seen.accumulator_left,
                     seen.resynced, seen.last);
         end
      end else begin
         want = due_results.pop_front();
         if (seen !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
               $display("%0t: result mismatch: expected upd=%0d delta=%0d acc=%0d rs=%0d last=%0d",
                        $time, want.update_now, want.smoothed_delta, want.accumulator_left,
                        want.resynced, want.last);
               $display("%0t:                  actual upd=%0d delta=%0d acc=%0d rs=%0d last=%0d",
                        $time, seen.update_now, seen.smoothed_delta, seen.accumulator_left,
                        seen.resynced, seen.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         period_reg   = RESET_PERIOD;
         base_reg     = RESET_PERIOD;
         tol_reg      = RESET_TOL;
         mult_reg     = RESET_MULT;
         prev_reading = '0;
         acc_reg      = '0;
         resync_armed = 1'b1;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            delta_hist[i] = 64'(RESET_PERIOD);
         end
         due_results.delete();
      end else begin
         // a result can never belong to a frame accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_PERIOD: period_reg = csr_data;
               CSR_VSYNC_BASE:   base_reg   = csr_data;
               CSR_SNAP_TOL:     tol_reg    = csr_data;
               CSR_UPDATE_MULT:  mult_reg   = csr_data[MULT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pace_frame(req_counter_value);
         end
      end
      pending_results <= due_results.size();
   end

endmodule

// ===== bench/tb_frame_pacing_timer.sv =====
// top of the frame pacing timer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_frame_pacing_timer;
   import frp_pkg::*;

   localparam int QUIET_LIMIT     = 3000;
   localparam int TAIL_CYCLES     = 24;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 21;
   localparam logic [COUNT_W-1:0] DEF_TICKS = COUNT_W'(RESET_PERIOD);

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_FRAME_PERIOD;
   logic [CFG_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COUNT_W-1:0]   req_counter_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_update_now;
   logic [DELTA_W-1:0]   rsp_smoothed_delta;
   logic [DELTA_W-1:0]   rsp_accumulator_left;
   logic                 rsp_resynced;
   logic                 rsp_last;

   int                   fail_count;
   int                   pending_results;
   int                   tx_idle_pct = 20;
   int                   rx_idle_pct = 60;
   int                   quiet_cycles = 0;

   logic [CFG_W-1:0]     cfg_period = RESET_PERIOD;
   logic [CFG_W-1:0]     cfg_base   = RESET_PERIOD;
   logic [CFG_W-1:0]     cfg_tol    = RESET_TOL;
   logic [MULT_W-1:0]    cfg_mult   = RESET_MULT;
   logic [COUNT_W-1:0]   last_reading = '0;

   frame_pacing_timer dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_counter_value    (req_counter_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_update_now       (rsp_update_now),
      .rsp_smoothed_delta   (rsp_smoothed_delta),
      .rsp_accumulator_left (rsp_accumulator_left),
      .rsp_resynced         (rsp_resynced),
      .rsp_last             (rsp_last)
   );

   frame_pacing_monitor u_monitor (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_counter_value    (req_counter_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_update_now       (rsp_update_now),
      .rsp_smoothed_delta   (rsp_smoothed_delta),
      .rsp_accumulator_left (rsp_accumulator_left),
      .rsp_resynced         (rsp_resynced),
      .rsp_last             (rsp_last),
      .fail_count           (fail_count),
      .pending_results      (pending_results)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // ends the run when no transaction moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_frame_pacing_timer: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_reading(input logic [COUNT_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_counter_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      last_reading = value;
   endtask

   task automatic send_step(input logic [COUNT_W-1:0] step);
      send_reading(last_reading + step);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // mostly plausible frame times around vsync multiples or the update period,
   // with slow frames, wraps, repeats and raw readings mixed in
   function automatic logic [COUNT_W-1:0] next_reading(input logic [COUNT_W-1:0] from);
      logic [63:0] per, base, span, jit, aim;
      int          pick, k;
      per  = 64'(cfg_period);
      base = 64'(cfg_base);
      span = 64'(cfg_tol) * 64'd4;
      if (span < 64'd4000) span = 64'd4000;
      if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
      jit  = {$urandom, $urandom} % (span + 64'd1);
      pick = $urandom_range(99);
      if (pick < 55) begin
         k   = $urandom_range(4);
         aim = (k == 4) ? (base + 64'd1) / 64'd2 : base * 64'(k + 1);
         return from + aim + jit - span / 64'd2;
      end
      if (pick < 70) begin
         return from + per * 64'($urandom_range(3, 1)) + jit - span / 64'd2;
      end
      if (pick < 80) begin
         if ($urandom_range(1) == 1) begin
            return from + per * 64'(SLOW_FACTOR) + 64'd1 + 64'($urandom);
         end
         return from + ({$urandom, $urandom} >> 2);
      end
      if (pick < 88) begin
         return from - 64'($urandom_range(100000, 1));
      end
      if (pick < 95) begin
         return {$urandom, $urandom};
      end
      return from;
   endfunction

   initial begin
      int ph, item;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first frame resync, each snap target, tolerance edges,
      // slow frame edge, sign edge of the difference, wraps and bit patterns
      send_reading('0);
      send_step(DEF_TICKS);
      send_step(DEF_TICKS * 2 + 1999);
      send_step(DEF_TICKS + 2000);
      send_step(DEF_TICKS - 2000);
      send_step(DEF_TICKS * 3 - 5);
      send_step(DEF_TICKS * 4 + 7);
      send_step((DEF_TICKS + 1) / 2);
      send_step(DEF_TICKS * SLOW_FACTOR);
      send_step(DEF_TICKS * SLOW_FACTOR + 1);
      send_step(DEF_TICKS + 1);
      send_step(64'h7FFF_FFFF_FFFF_FFFF);
      send_step(64'h8000_0000_0000_0000);
      send_step('1);
      send_reading('1);
      send_reading('0);
      send_reading(64'h5555_5555_5555_5555);
      send_reading(64'hAAAA_AAAA_AAAA_AAAA);
      send_step('0);
      send_step(DEF_TICKS);
      send_step(DEF_TICKS - 1999);
      send_step(DEF_TICKS);

      for (ph = 0; ph < PHASES; ph++) begin
         drain_frames();
         case (ph)
            0: begin
               cfg_period = RESET_PERIOD; cfg_base = RESET_PERIOD;
               cfg_tol = RESET_TOL; cfg_mult = RESET_MULT;
            end
            1: begin
               cfg_period = 83333; cfg_base = RESET_PERIOD; cfg_tol = 5000; cfg_mult = 2;
            end
            2: begin
               cfg_period = 1; cfg_base = 1; cfg_tol = 0; cfg_mult = 8;
            end
            3: begin
               cfg_period = '1; cfg_base = '1; cfg_tol = '1; cfg_mult = 1;
            end
            4: begin
               cfg_period = 1000; cfg_base = 16667; cfg_tol = 100; cfg_mult = 3;
            end
            5: begin
               // zero multiplicity behaves as one
               cfg_period = 50000; cfg_base = RESET_PERIOD; cfg_tol = 1; cfg_mult = 0;
            end
            6: begin
               // a group larger than a frame's pulse budget never fires
               cfg_period = 20000; cfg_base = RESET_PERIOD; cfg_tol = 3000; cfg_mult = 12;
            end
            7: begin
               cfg_period = 0; cfg_base = RESET_PERIOD; cfg_tol = 2000; cfg_mult = 1;
            end
            default: begin
               cfg_period = $urandom_range(400000, 1000);
               cfg_base   = $urandom_range(400000, 1000);
               cfg_tol    = $urandom_range(20000, 0);
               cfg_mult   = $urandom_range(8, 1);
            end
         endcase
         write_reg(CSR_FRAME_PERIOD, cfg_period);
         write_reg(CSR_VSYNC_BASE, cfg_base);
         write_reg(CSR_SNAP_TOL, cfg_tol);
         write_reg(CSR_UPDATE_MULT, CFG_W'(cfg_mult));
         csr_valid <= 1'b0;
         if (ph < 3) begin
            tx_idle_pct = 20;
            rx_idle_pct = 60;
         end else if (ph < 6) begin
            tx_idle_pct = 60;
            rx_idle_pct = 20;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_reading(next_reading(last_reading));
         end
      end

      drain_frames();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_frame_pacing_timer: PASS");
      end else begin
         $display("tb_frame_pacing_timer: FAIL");
      end
      $finish;
   end

endmodule
